// File: rtl/core/json_string_unescape_utf8_macros.svh
// Assertion macros shared by the JSON string unescape RTL.
// Used by files that `include this header; expects clk and rst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define JSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/jsu_pkg.sv
// Package for the JSON string unescape block: phase and status codes,
// the result group passed from front to back, UTF-8 and hex helpers.
// No dependencies.
package jsu_pkg;

    // Decoder phase, one per kind of pending escape or sequence
    typedef enum logic [3:0] {
        PH_PLAIN   = 4'd0,
        PH_ESC     = 4'd1,
        PH_HEX1    = 4'd2,
        PH_PAIR_BS = 4'd3,
        PH_PAIR_U  = 4'd4,
        PH_HEX2    = 4'd5,
        PH_CONT    = 4'd6
    } phase_t;

    // End-of-string status
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BADCHAR   = 2'd1,
        ST_EARLY_END = 2'd2
    } status_t;

    // All results caused by one input beat: up to four bytes, then an end marker
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            has_end;
        status_t         status;
    } group_t;

    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Code point to UTF-8, first byte in bytes[0]
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // ASCII hex digit, either case
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r.ok    = 1'b1;
            r.value = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r.ok    = 1'b1;
            r.value = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/jsu_if.sv
// Handshake channels of the JSON string unescape block: input bytes and results.
// No dependencies.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, in_byte, end_of_input, input ready);
    modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;

    modport source (output valid, out_byte, byte_valid, done_res, status, input ready);
    modport sink   (input valid, out_byte, byte_valid, done_res, status, output ready);
endinterface

// File: rtl/core/jsu_front.sv
// Front end: accepts input beats, runs the escape / UTF-8 decoder state
// and pushes one group per beat that has results. Depends on jsu_pkg, jsu_if, macros.
`include "json_string_unescape_utf8_macros.svh"

module jsu_front (
    input  logic           clk,
    input  logic           rst_n,
    jsu_in_if.sink         data,
    input  logic           q_full,
    output logic           push,
    output jsu_pkg::group_t push_grp
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  digits_reg, digits_next;
    logic [9:0]  surr_reg, surr_next;
    logic [1:0]  cont_reg, cont_next;
    logic        limit_reg, limit_next;

    logic            accept;
    logic [7:0]      b;
    hex_t            hx;
    logic [15:0]     acc_shift;
    logic            last_digit;
    logic [20:0]     pair_cp;
    logic [1:0]      cont_dec;
    utf8_t           enc;
    logic            bad;
    logic            done;
    logic            has_end;

    assign data.ready = !q_full;
    assign accept     = data.valid && data.ready;
    assign b          = data.in_byte;

    // Decoder next state and emitted bytes
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        surr_next   = surr_reg;
        cont_next   = cont_reg;
        limit_next  = limit_reg;
        bad         = 1'b0;
        done        = 1'b0;
        enc         = '0;
        hx          = hex_decode(b);
        acc_shift   = {acc_reg[11:0], hx.value};
        last_digit  = (digits_reg == 3'd3);
        pair_cp     = 21'h10000 + {1'b0, surr_reg, acc_shift[9:0]};
        cont_dec    = (cont_reg != 2'd0) ? cont_reg - 2'd1 : 2'd0;

        case (phase_reg)
            PH_ESC:
            begin
                phase_next = PH_PLAIN;
                enc.count  = 3'd1;
                case (b)
                    CH_U:
                    begin
                        enc.count   = 3'd0;
                        phase_next  = PH_HEX1;
                        acc_next    = '0;
                        digits_next = '0;
                    end
                    CH_BSLASH, CH_SLASH, CH_QUOTE: enc.bytes[0] = b;
                    CH_N: enc.bytes[0] = 8'h0A;
                    CH_R: enc.bytes[0] = 8'h0D;
                    CH_T: enc.bytes[0] = 8'h09;
                    CH_F: enc.bytes[0] = 8'h0C;
                    CH_B: enc.bytes[0] = 8'h08;
                    default:
                    begin
                        enc.count = 3'd0;
                        bad       = 1'b1;
                    end
                endcase
            end
            PH_HEX1, PH_HEX2:
            begin
                if (!hx.ok) begin
                    bad = 1'b1;
                end
                else begin
                    acc_next    = acc_shift;
                    digits_next = last_digit ? 3'd0 : digits_reg + 3'd1;
                    if (last_digit) begin
                        if (phase_reg == PH_HEX2) begin
                            // low half of a surrogate pair
                            if (acc_shift inside {[16'hDC00:16'hDFFF]}) begin
                                enc        = utf8_encode(pair_cp);
                                phase_next = PH_PLAIN;
                            end
                            else begin
                                bad = 1'b1;
                            end
                        end
                        else if (acc_shift inside {[16'hD800:16'hDBFF]}) begin
                            surr_next  = acc_shift[9:0];
                            phase_next = PH_PAIR_BS;
                        end
                        else if (acc_shift inside {[16'hDC00:16'hDFFF]}) begin
                            bad = 1'b1;
                        end
                        else begin
                            enc        = utf8_encode({5'd0, acc_shift});
                            phase_next = PH_PLAIN;
                        end
                    end
                end
            end
            PH_PAIR_BS:
            begin
                if (b == CH_BSLASH) phase_next = PH_PAIR_U;
                else                bad        = 1'b1;
            end
            PH_PAIR_U:
            begin
                if (b == CH_U) begin
                    phase_next  = PH_HEX2;
                    acc_next    = '0;
                    digits_next = '0;
                end
                else begin
                    bad = 1'b1;
                end
            end
            PH_CONT:
            begin
                if (!(b inside {[8'h80:8'hBF]}) || (limit_reg && b >= 8'h90)) begin
                    bad = 1'b1;
                end
                else begin
                    enc.count    = 3'd1;
                    enc.bytes[0] = b;
                    limit_next   = 1'b0;
                    cont_next    = cont_dec;
                    if (cont_dec == 2'd0) phase_next = PH_PLAIN;
                end
            end
            default:
            begin
                // plain text
                phase_next   = PH_PLAIN;
                enc.bytes[0] = b;
                if (b == CH_QUOTE) begin
                    done = 1'b1;
                end
                else if (b == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end
                else if (b inside {[8'hC0:8'hDF]}) begin
                    enc.count  = 3'd1;
                    cont_next  = 2'd1;
                    phase_next = PH_CONT;
                end
                else if (b inside {[8'hE0:8'hEF]}) begin
                    enc.count  = 3'd1;
                    cont_next  = 2'd2;
                    phase_next = PH_CONT;
                end
                else if (b inside {[8'hF0:8'hF4]}) begin
                    enc.count  = 3'd1;
                    cont_next  = 2'd3;
                    limit_next = (b == 8'hF4);
                    phase_next = PH_CONT;
                end
                else if (b inside {[8'hF5:8'hFD]}) begin
                    bad = 1'b1;
                end
                else begin
                    enc.count = 3'd1;
                end
            end
        endcase

        has_end = bad || done || data.end_of_input;

        // any end result returns the decoder to its reset state
        if (has_end) begin
            phase_next  = PH_PLAIN;
            acc_next    = '0;
            digits_next = '0;
            surr_next   = '0;
            cont_next   = '0;
            limit_next  = 1'b0;
        end
    end

    // Group toward the queue; empty groups are dropped
    always_comb
    begin
        push_grp.bytes   = enc.bytes;
        push_grp.nbytes  = enc.count;
        push_grp.has_end = has_end;
        if (bad)       push_grp.status = ST_BADCHAR;
        else if (done) push_grp.status = ST_OK;
        else           push_grp.status = ST_EARLY_END;
        push = accept && (has_end || (enc.count != 3'd0));
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_PLAIN;
            acc_reg    <= '0;
            digits_reg <= '0;
            surr_reg   <= '0;
            cont_reg   <= '0;
            limit_reg  <= 1'b0;
        end
        else if (accept) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            surr_reg   <= surr_next;
            cont_reg   <= cont_next;
            limit_reg  <= limit_next;
        end
    end

    `JSU_ASSERT_NEXT(a_end_clears_state, accept && has_end,
        phase_reg == PH_PLAIN && digits_reg == 3'd0 && cont_reg == 2'd0,
        "decoder state not cleared after end result")
    `JSU_ASSERT_IMPL(a_no_push_when_full, push, !q_full,
        "group pushed into a full queue")

endmodule

// File: rtl/core/jsu_queue.sv
// Short FIFO of result groups between the decoder front and the output back.
// Depends on jsu_pkg and the assertion macros.
`include "json_string_unescape_utf8_macros.svh"

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::group_t push_grp,
    output logic            full,
    input  logic            pop,
    output jsu_pkg::group_t head_grp,
    output logic            empty
);
    import jsu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_grp = entries_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push) entries_reg[wr_ptr_reg] <= push_grp;
    end

    `JSU_ASSERT(a_count_in_range, count_reg <= CNT_W'(DEPTH),
        "queue fill count exceeds depth")
    `JSU_ASSERT_IMPL(a_no_pop_empty, pop, !empty,
        "pop from an empty queue")

endmodule

// File: rtl/core/jsu_back.sv
// Back end: walks the head group one result per beat into a registered
// output stage. Depends on jsu_pkg, jsu_if and the assertion macros.
`include "json_string_unescape_utf8_macros.svh"

module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  jsu_pkg::group_t head_grp,
    input  logic            empty,
    output logic            pop,
    jsu_out_if.source       result
);
    import jsu_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       ov_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg;
    logic       done_reg;
    status_t    status_reg;

    logic [2:0] total;
    logic       last;
    logic       load;
    logic       is_byte;

    assign total   = head_grp.nbytes + {2'd0, head_grp.has_end};
    assign last    = ((idx_reg + 3'd1) == total);
    assign load    = !empty && (!ov_reg || result.ready);
    assign pop     = load && last;
    assign is_byte = (idx_reg < head_grp.nbytes);

    always_comb
    begin
        idx_next = idx_reg;
        if (load) idx_next = last ? 3'd0 : idx_reg + 3'd1;
    end

    // Control: valid flag and position within the head group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else begin
            idx_reg <= idx_next;
            if (load)              ov_reg <= 1'b1;
            else if (result.ready) ov_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg   <= is_byte ? head_grp.bytes[idx_reg[1:0]] : 8'd0;
            bvalid_reg <= is_byte;
            done_reg   <= !is_byte;
            status_reg <= is_byte ? ST_OK : head_grp.status;
        end
    end

    assign result.valid      = ov_reg;
    assign result.out_byte   = byte_reg;
    assign result.byte_valid = bvalid_reg;
    assign result.done_res   = done_reg;
    assign result.status     = status_reg;

    `JSU_ASSERT_NEXT(a_stall_holds_idx, ov_reg && !result.ready, $stable(idx_reg),
        "group position moved while output stalled")

endmodule

// File: rtl/core/json_string_unescape_utf8.sv
// Top level of the JSON string unescape / UTF-8 check block.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue, jsu_back.
//
// Usage:
//   data   : input beats, one byte of a JSON string body each (after the
//            opening quote), with end_of_input on the last buffered byte.
//   result : output beats, either a decoded byte (byte_valid = 1) or the
//            end marker of a string (done_res = 1, status 0 ok, 1 bad
//            character, 2 input ended early). After an end marker the next
//            input byte starts a new string.
//   Path:    the first result of a byte is written into the group queue when
//            the byte is taken, then loaded into the output reg and offered.
//   Throughput: one input beat per cycle while each byte gives at most one
//            result and result.ready stays high. While ready is high, the
//            output register sends one result per cycle; the results of a \u
//            escape (up to four bytes plus an end marker) go out in turn. A
//            QUEUE_DEPTH-entry group queue lets the decoder run ahead of output.
//   Stall: when result.ready is low the output register holds its beat,
//            the queue fills and data.ready drops once it is full.
//   Reset: rst_n clears the decoder to plain text and empties the queue.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    data,
    jsu_out_if.source result
);
    import jsu_pkg::*;

    logic   push;
    group_t push_grp;
    logic   full;
    logic   pop;
    group_t head_grp;
    logic   empty;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .data     (data),
        .q_full   (full),
        .push     (push),
        .push_grp (push_grp)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .full     (full),
        .pop      (pop),
        .head_grp (head_grp),
        .empty    (empty)
    );

    jsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_grp (head_grp),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
